// ===== rtl/silence_gap_track_splitter_macros.svh =====
// Assertion macros for the silence-gap track splitter.
// Included by silence_gap_track_splitter.sv, which checks its own logic; no other dependencies.
`ifndef SILENCE_GAP_TRACK_SPLITTER_MACROS_SVH
`define SILENCE_GAP_TRACK_SPLITTER_MACROS_SVH
`ifndef SYNTHESIS
// condition must hold on every edge outside reset
`define SGTS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// same-cycle implication
`define SGTS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SGTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SGTS_ASSERT_ALWAYS(lbl, cond, msg)
`define SGTS_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define SGTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/sgts_pkg.sv =====
// Package for the silence-gap track splitter: constants, register map, result type.
// No dependencies.
package sgts_pkg;

  localparam logic [6:0]  MAX_TRACKS = 7'd99;
  localparam logic [24:0] QUIET_MAX  = 25'h1FF_FFFF;

  // register reset values
  localparam logic [15:0] THRESHOLD_RST = 16'd500;
  localparam logic [23:0] GAP_RST       = 24'd132300;
  localparam logic [30:0] MIN_TRACK_RST = 31'd13230000;

  typedef enum logic [1:0] {
    FMT_OTHER  = 2'd0,
    FMT_MONO   = 2'd1,
    FMT_STEREO = 2'd2,
    FMT_RSVD   = 2'd3
  } sample_format_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_GAP       = 2'd1,
    REG_MIN_TRACK = 2'd2,
    REG_FORMAT    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [6:0] track_number;
    logic       track_end;
    logic       halted_error;
  } result_t;

  // absolute value of a 16-bit two's complement sample, 17 bits wide
  function automatic logic [16:0] mag16(input logic signed [15:0] s);
    logic [16:0] ext;
    ext = {s[15], s};
    return s[15] ? 17'(-ext) : ext;
  endfunction

endpackage

// ===== rtl/silence_gap_track_splitter.sv =====
// Silence-gap track splitter: top level with APB register block, track logic and output skid.
// Depends on sgts_pkg and silence_gap_track_splitter_macros.svh.
//
// Tags each audio frame with the number of the track it belongs to. Every
// track opens with min_track_frames frames passed through unscanned; after
// that a frame is loud when |left| (or |right| in stereo) exceeds threshold,
// and a quiet frame more than gap_frames frames after the last loud one
// closes the track. Format 0 or 3 never splits. A word with tlast closes its
// track and returns all track state to its start values. Needing a 100th
// track halts the block: frames are then returned with halted_error set and
// track number 0 until the next tlast. Throughput is one frame per clock
// while the skid register is empty: the whole decision is a few compares
// and counter increments from the track state to a result register, with a
// second (skid) register so that s_axis_tready is a flop and keeps accepting
// while one result is stalled. Registers sit on APB at 0x0 threshold, 0x4
// gap_frames, 0x8 min_track_frames, 0xC format; write them only while no
// frame is in flight.
`include "silence_gap_track_splitter_macros.svh"

module silence_gap_track_splitter (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // frame input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] left_sample, [31:16] right_sample
  input  logic        s_axis_tlast,   // last_frame
  // tagged output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] track_number, [7] zero
  output logic        m_axis_tlast,   // track_end
  output logic        m_axis_tuser    // halted_error
);

  // ---------------------------------------------------------------- registers
  logic [15:0] threshold;
  logic [23:0] gap_frames;
  logic [30:0] min_track_frames;
  sgts_pkg::sample_format_t sample_format;

  logic cfg_wr;
  sgts_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = sgts_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold        <= sgts_pkg::THRESHOLD_RST;
      gap_frames       <= sgts_pkg::GAP_RST;
      min_track_frames <= sgts_pkg::MIN_TRACK_RST;
      sample_format    <= sgts_pkg::FMT_STEREO;
    end else if (cfg_wr) begin
      case (cfg_idx)
        sgts_pkg::REG_THRESHOLD: threshold        <= pwdata[15:0];
        sgts_pkg::REG_GAP:       gap_frames       <= pwdata[23:0];
        sgts_pkg::REG_MIN_TRACK: min_track_frames <= pwdata[30:0];
        sgts_pkg::REG_FORMAT:    sample_format    <= sgts_pkg::sample_format_t'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      sgts_pkg::REG_THRESHOLD: prdata = {16'd0, threshold};
      sgts_pkg::REG_GAP:       prdata = {8'd0, gap_frames};
      sgts_pkg::REG_MIN_TRACK: prdata = {1'b0, min_track_frames};
      sgts_pkg::REG_FORMAT:    prdata = {30'd0, sample_format};
      default:                 prdata = 32'd0;
    endcase
  end

  // -------------------------------------------------------------- track state
  logic [6:0]  track_count,     track_count_next;
  logic        track_open,      track_open_next;
  logic        in_scan_phase,   in_scan_phase_next;
  logic [30:0] min_phase_count, min_phase_count_next;
  logic [24:0] quiet_run,       quiet_run_next;
  logic        halted,          halted_next;

  logic        in_acc;
  logic signed [15:0] left_sample, right_sample;
  logic        last_frame;

  // per-frame working values
  logic        opening, halt_now, halt_eff;
  logic [6:0]  tc_eff;
  logic        scan0, enter_scan, scan1, scanning_fmt, loud, gap_end;
  logic [30:0] mpc0;
  logic [24:0] qr0, qr1, qr2;
  sgts_pkg::result_t res;

  assign left_sample  = s_axis_tdata[15:0];
  assign right_sample = s_axis_tdata[31:16];
  assign last_frame   = s_axis_tlast;
  assign in_acc       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    // open a track if none is open
    opening  = !halted && !track_open;
    halt_now = opening && (track_count >= sgts_pkg::MAX_TRACKS);
    halt_eff = halted || halt_now;
    tc_eff   = (opening && !halt_now) ? 7'(track_count + 7'd1) : track_count;
    scan0    = opening ? 1'b0  : in_scan_phase;
    mpc0     = opening ? '0    : min_phase_count;
    qr0      = opening ? '0    : quiet_run;

    // minimum phase over: start scanning with this frame
    enter_scan = !scan0 && (mpc0 >= min_track_frames);
    scan1      = scan0 || enter_scan;
    qr1        = enter_scan ? '0 : qr0;

    scanning_fmt = (sample_format == sgts_pkg::FMT_MONO) ||
                   (sample_format == sgts_pkg::FMT_STEREO);
    loud = (sgts_pkg::mag16(left_sample) > {1'b0, threshold}) ||
           ((sample_format == sgts_pkg::FMT_STEREO) &&
            (sgts_pkg::mag16(right_sample) > {1'b0, threshold}));

    gap_end = 1'b0;
    qr2     = qr1;
    if (scan1 && scanning_fmt) begin
      if (loud) begin
        qr2 = 25'd1;
      end else if (qr1 > {1'b0, gap_frames}) begin
        gap_end = 1'b1;
      end else if (qr1 < sgts_pkg::QUIET_MAX) begin
        qr2 = 25'(qr1 + 25'd1);
      end
    end

    if (halt_eff) begin
      res.track_number = '0;
      res.track_end    = 1'b0;
      res.halted_error = 1'b1;
    end else begin
      res.track_number = tc_eff;
      res.track_end    = gap_end || last_frame;
      res.halted_error = 1'b0;
    end

    // next state, applied only on an accepted word
    track_count_next     = tc_eff;
    track_open_next      = 1'b1;
    in_scan_phase_next   = scan1;
    min_phase_count_next = scan1 ? mpc0 : 31'(mpc0 + 31'd1);
    quiet_run_next       = qr2;
    halted_next          = 1'b0;
    if (last_frame) begin
      track_count_next     = '0;
      track_open_next      = 1'b0;
      in_scan_phase_next   = 1'b0;
      min_phase_count_next = '0;
      quiet_run_next       = '0;
    end else if (halt_eff) begin
      track_count_next     = track_count;
      track_open_next      = 1'b0;
      in_scan_phase_next   = 1'b0;
      min_phase_count_next = '0;
      quiet_run_next       = '0;
      halted_next          = 1'b1;
    end else if (gap_end) begin
      track_open_next      = 1'b0;
      in_scan_phase_next   = 1'b0;
      min_phase_count_next = '0;
      quiet_run_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      track_count     <= '0;
      track_open      <= 1'b0;
      in_scan_phase   <= 1'b0;
      min_phase_count <= '0;
      quiet_run       <= '0;
      halted          <= 1'b0;
    end else if (in_acc) begin
      track_count     <= track_count_next;
      track_open      <= track_open_next;
      in_scan_phase   <= in_scan_phase_next;
      min_phase_count <= min_phase_count_next;
      quiet_run       <= quiet_run_next;
      halted          <= halted_next;
    end
  end

  // ------------------------------------------------------ output + skid stage
  logic              out_valid, skid_valid;
  sgts_pkg::result_t out_word, skid_word;
  logic              pop;

  assign pop           = out_valid && m_axis_tready;
  assign s_axis_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_word <= skid_word;
      end
    end else if (in_acc) begin
      if (!out_valid || pop) begin
        out_word <= res;
      end else begin
        skid_word <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_word.track_number};
  assign m_axis_tlast  = out_word.track_end;
  assign m_axis_tuser  = out_word.halted_error;

  // ---------------------------------------------------------------- checks
  `SGTS_ASSERT_IMPLIES(a_skid_behind_out, skid_valid, out_valid, "skid word without output word")
  `SGTS_ASSERT_ALWAYS(a_track_limit, track_count <= sgts_pkg::MAX_TRACKS, "track count over limit")
  `SGTS_ASSERT_IMPLIES(a_halt_closed, halted, !track_open && !in_scan_phase, "open track while halted")
  `SGTS_ASSERT_IMPLIES(a_quiet_in_scan, quiet_run != '0, in_scan_phase, "quiet run outside scan phase")
  `SGTS_ASSERT_NEXT(a_stall_to_skid, in_acc && out_valid && !m_axis_tready, skid_valid, "stalled word lost")

endmodule
